// ===== rtl/mcss_pkg.sv =====
// ----------------------------------------------------------------------------
// mcss_pkg
// Shared types and constants of the Markov chain state sampler.
// ----------------------------------------------------------------------------
package mcss_pkg;

    // Operation carried by each input transaction. Codes five to seven are
    // not defined and are rejected with an error status.
    typedef enum logic [2:0] {
        OP_STEP          = 3'd0,
        OP_SET_STATE     = 3'd1,
        OP_WRITE_WEIGHT  = 3'd2,
        OP_RESET_UNIFORM = 3'd3,
        OP_RESIZE        = 3'd4
    } opcode_t;

    // Widths of the fields on the ports.
    localparam int OPCODE_W    = 3;
    localparam int FRAC_IN_W   = 16;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 4;
    localparam int WEIGHT_IN_W = 16;
    localparam int COUNT_W     = 5;
    localparam int STATE_NUM_W = 5;

    // Input tdata layout, lowest bit first.
    localparam int FRAC_LSB    = 0;
    localparam int ROW_LSB     = FRAC_LSB + FRAC_IN_W;
    localparam int COL_LSB     = ROW_LSB + ROW_W;
    localparam int WEIGHT_LSB  = COL_LSB + COL_W;
    localparam int COUNT_LSB   = WEIGHT_LSB + WEIGHT_IN_W;
    localparam int S_FIELDS_W  = COUNT_LSB + COUNT_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int M_FIELDS_W  = STATE_NUM_W + 1;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Status codes of a result.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

endpackage

// ===== rtl/mcss_ram.sv =====
// ----------------------------------------------------------------------------
// mcss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/markov_chain_state_sampler_core.sv =====
// ----------------------------------------------------------------------------
// markov_chain_state_sampler_core
// Markov chain sampler that picks the next state by inverse-CDF selection over
// a table of unnormalised integer transition weights.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Signals                    | Contents
//  --------+-----+----------------------------+---------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata  | operation, fraction, indices,
//          |     | s_tuser                    | weight, state count
//  m_      | out | m_tvalid m_tready m_tdata  | one-based state number, status
//
//  A step walks the columns of the current row until the threshold is passed,
//  at most the states in use; the single read port of the weight memory
//  delivers one column per cycle. The first weight write to a row after a
//  uniform reset first fills the whole row with ones, the new weight in its
//  column. Set state, reset uniform, resize and unknown operations go
//  straight from idle to the response state.
//  Reset is synchronous and active low; it clears the row valid flags, so no
//  clearing pass over the memories is needed. A stalled result is held in the
//  output register; the next transaction is still accepted and worked, and its
//  result waits until the earlier one has been taken.
//
module markov_chain_state_sampler_core #(
    parameter int MAX_STATES    = 16,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: random_fraction[15:0], row_index[19:16],
    // column_index[23:20], weight_value[39:24], new_state_count[44:40], zeros.
    input  logic [mcss_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: opcode[2:0].
    input  logic [mcss_pkg::OPCODE_W-1:0]  s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: state_number[4:0], status[5], zeros.
    output logic [mcss_pkg::M_TDATA_W-1:0] m_tdata
);

    // Index of one row or one column of the weight table.
    localparam int IDX_W   = $clog2(MAX_STATES);
    // Holds the state count, and the reset count of three for any table size.
    localparam int CNT_W   = (MAX_STATES < 3) ? 2 : $clog2(MAX_STATES + 1);
    // A row sum never exceeds MAX_STATES full-scale weights.
    localparam int SUM_W   = WEIGHT_BITS + IDX_W;
    localparam int PROD_W  = mcss_pkg::FRAC_IN_W + SUM_W;
    localparam int CMP_W   = PROD_W + FRACTION_BITS;
    localparam int WADDR_W = 2 * IDX_W;
    localparam logic [mcss_pkg::FRAC_IN_W-1:0] FRAC_MASK =
        (FRACTION_BITS >= mcss_pkg::FRAC_IN_W) ? {mcss_pkg::FRAC_IN_W{1'b1}} :
        mcss_pkg::FRAC_IN_W'((64'd1 << FRACTION_BITS) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_SUM,
        ST_STEP_WALK,
        ST_WR_READ,
        ST_WR_FILL,
        ST_RESP
    } fsm_t;

    // Unpacked input fields.
    mcss_pkg::opcode_t                     in_op;
    logic [mcss_pkg::FRAC_IN_W-1:0]        in_frac;
    logic [mcss_pkg::ROW_W-1:0]            in_row;
    logic [mcss_pkg::COL_W-1:0]            in_col;
    logic [mcss_pkg::WEIGHT_IN_W-1:0]      in_weight;
    logic [mcss_pkg::COUNT_W-1:0]          in_count;

    fsm_t                                  state_reg;
    logic [CNT_W-1:0]                      cur_reg;
    logic [CNT_W-1:0]                      siu_reg;
    logic [MAX_STATES-1:0]                 row_valid_reg;
    logic [IDX_W-1:0]                      row_reg;
    logic [IDX_W-1:0]                      col_reg;
    logic [IDX_W-1:0]                      walk_reg;
    logic [mcss_pkg::FRAC_IN_W-1:0]        frac_reg;
    logic [WEIGHT_BITS-1:0]                wgt_reg;
    logic [SUM_W-1:0]                      cum_reg;
    logic [PROD_W-1:0]                     prod_reg;
    logic                                  res_status_reg;
    logic                                  m_valid_reg;
    logic [mcss_pkg::STATE_NUM_W-1:0]      m_state_reg;
    logic                                  m_status_reg;

    // Memory ports.
    logic                                  wt_we;
    logic [WADDR_W-1:0]                    wt_waddr;
    logic [WEIGHT_BITS-1:0]                wt_wdata;
    logic [WADDR_W-1:0]                    wt_raddr;
    logic [WEIGHT_BITS-1:0]                wt_rdata;
    logic                                  sum_we;
    logic [IDX_W-1:0]                      sum_raddr;
    logic [SUM_W-1:0]                      sum_rdata;

    // Datapath values.
    logic                                  row_ok;
    logic [WEIGHT_BITS-1:0]                wt_eff;
    logic [SUM_W-1:0]                      sum_eff;
    logic [SUM_W-1:0]                      sum_new;
    logic [SUM_W-1:0]                      cum_next;
    logic                                  walk_hit;
    logic                                  walk_last;
    logic                                  fill_last;
    logic                                  out_free;
    logic                                  accept;

    assign in_op     = mcss_pkg::opcode_t'(s_tuser);
    assign in_frac   = s_tdata[mcss_pkg::FRAC_LSB +: mcss_pkg::FRAC_IN_W];
    assign in_row    = s_tdata[mcss_pkg::ROW_LSB +: mcss_pkg::ROW_W];
    assign in_col    = s_tdata[mcss_pkg::COL_LSB +: mcss_pkg::COL_W];
    assign in_weight = s_tdata[mcss_pkg::WEIGHT_LSB +: mcss_pkg::WEIGHT_IN_W];
    assign in_count  = s_tdata[mcss_pkg::COUNT_LSB +: mcss_pkg::COUNT_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // A row that has not been written since the last uniform reset holds ones
    // and sums to the number of states in use, whatever its memory holds.
    assign row_ok  = row_valid_reg[row_reg];
    assign wt_eff  = row_ok ? wt_rdata : WEIGHT_BITS'(1);
    assign sum_eff = row_ok ? sum_rdata : SUM_W'(siu_reg);
    assign sum_new = sum_eff - SUM_W'(wt_eff) + SUM_W'(wgt_reg);

    // The threshold floor(f * sum / 2^F) lies below the cumulative weight
    // exactly when the full product lies below the cumulative weight scaled up.
    assign cum_next  = cum_reg + SUM_W'(wt_eff);
    assign walk_hit  = CMP_W'(prod_reg) < (CMP_W'(cum_next) << FRACTION_BITS);
    assign walk_last = (32'(walk_reg) + 32'd1 >= 32'(siu_reg)) ||
                       (32'(walk_reg) == MAX_STATES - 1);
    assign fill_last = (32'(walk_reg) == MAX_STATES - 1);

    // Memory addressing. In idle the addresses come straight from the incoming
    // transaction, or from the current state for the row sum of a step, so that the data is ready in the next cycle.
    always_comb begin
        if (state_reg == ST_IDLE) begin
            sum_raddr = (in_op == mcss_pkg::OP_WRITE_WEIGHT) ? IDX_W'(in_row)
                                                             : IDX_W'(cur_reg);
            wt_raddr  = {IDX_W'(in_row), IDX_W'(in_col)};
        end else if (state_reg == ST_STEP_SUM) begin
            sum_raddr = row_reg;
            wt_raddr  = {row_reg, IDX_W'(0)};
        end else begin
            sum_raddr = row_reg;
            wt_raddr  = {row_reg, IDX_W'(walk_reg + 1'b1)};
        end
    end

    always_comb begin
        sum_we   = (state_reg == ST_WR_READ);
        wt_we    = 1'b0;
        wt_waddr = {row_reg, col_reg};
        wt_wdata = wgt_reg;
        if (state_reg == ST_WR_READ) begin
            wt_we = row_ok;
        end else if (state_reg == ST_WR_FILL) begin
            wt_we    = 1'b1;
            wt_waddr = {row_reg, walk_reg};
            wt_wdata = (walk_reg == col_reg) ? wgt_reg : WEIGHT_BITS'(1);
        end
    end

    mcss_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (1 << WADDR_W)
    ) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (wt_we),
        .wr_addr (wt_waddr),
        .wr_data (wt_wdata),
        .rd_addr (wt_raddr),
        .rd_data (wt_rdata)
    );

    mcss_ram #(
        .WIDTH (SUM_W),
        .DEPTH (1 << IDX_W)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_we),
        .wr_addr (row_reg),
        .wr_data (sum_new),
        .rd_addr (sum_raddr),
        .rd_data (sum_rdata)
    );

    // Sequencer, architectural state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            siu_reg        <= CNT_W'(3);
            row_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
            res_status_reg <= mcss_pkg::STATUS_OK;
        end else begin
            // The output register is loaded from the response state and
            // emptied when the receiver takes the transaction.
            if ((state_reg == ST_RESP) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        frac_reg       <= in_frac & FRAC_MASK;
                        wgt_reg        <= WEIGHT_BITS'(in_weight);
                        col_reg        <= IDX_W'(in_col);
                        res_status_reg <= mcss_pkg::STATUS_OK;
                        state_reg      <= ST_RESP;
                        case (in_op)
                            mcss_pkg::OP_STEP: begin
                                row_reg <= IDX_W'(cur_reg);
                                // A current state outside the table has no row.
                                if (32'(cur_reg) < MAX_STATES) begin
                                    state_reg <= ST_STEP_SUM;
                                end
                            end
                            mcss_pkg::OP_SET_STATE: begin
                                if (32'(in_row) < 32'(siu_reg)) begin
                                    cur_reg <= CNT_W'(in_row);
                                end else begin
                                    res_status_reg <= mcss_pkg::STATUS_ERROR;
                                end
                            end
                            mcss_pkg::OP_WRITE_WEIGHT: begin
                                row_reg <= IDX_W'(in_row);
                                if ((32'(in_row) < 32'(siu_reg)) &&
                                    (32'(in_col) < 32'(siu_reg))) begin
                                    state_reg <= ST_WR_READ;
                                end else begin
                                    res_status_reg <= mcss_pkg::STATUS_ERROR;
                                end
                            end
                            mcss_pkg::OP_RESET_UNIFORM: begin
                                row_valid_reg <= '0;
                            end
                            mcss_pkg::OP_RESIZE: begin
                                if ((in_count != '0) &&
                                    (32'(in_count) <= MAX_STATES)) begin
                                    siu_reg       <= CNT_W'(in_count);
                                    row_valid_reg <= '0;
                                    if (32'(cur_reg) >= 32'(in_count)) begin
                                        cur_reg <= '0;
                                    end
                                end else begin
                                    res_status_reg <= mcss_pkg::STATUS_ERROR;
                                end
                            end
                            default: begin
                                res_status_reg <= mcss_pkg::STATUS_ERROR;
                            end
                        endcase
                    end
                end
                ST_STEP_SUM: begin
                    // A row that sums to zero leaves the state where it is.
                    if (sum_eff == '0) begin
                        state_reg <= ST_RESP;
                    end else begin
                        prod_reg  <= PROD_W'(frac_reg) * PROD_W'(sum_eff);
                        cum_reg   <= '0;
                        walk_reg  <= '0;
                        state_reg <= ST_STEP_WALK;
                    end
                end
                ST_STEP_WALK: begin
                    cum_reg  <= cum_next;
                    walk_reg <= walk_reg + 1'b1;
                    if (walk_hit) begin
                        cur_reg   <= CNT_W'(walk_reg);
                        state_reg <= ST_RESP;
                    end else if (walk_last) begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_WR_READ: begin
                    walk_reg <= '0;
                    if (row_ok) begin
                        state_reg <= ST_RESP;
                    end else begin
                        state_reg <= ST_WR_FILL;
                    end
                end
                ST_WR_FILL: begin
                    walk_reg <= walk_reg + 1'b1;
                    if (fill_last) begin
                        row_valid_reg[row_reg] <= 1'b1;
                        state_reg              <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_state_reg  <= mcss_pkg::STATE_NUM_W'(32'(cur_reg) + 32'd1);
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mcss_pkg::M_TDATA_W - mcss_pkg::M_FIELDS_W){1'b0}},
                       m_status_reg, m_state_reg};

`ifndef SYNTH
    // One transaction at a time: the block is busy right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted while an earlier transaction is in work");

    // The current state always lies among the states in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cur_reg) < 32'(siu_reg))
        else $error("current state outside the states in use");

    // The walk never reads a column beyond the states in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP_WALK) |-> (32'(walk_reg) < 32'(siu_reg)))
        else $error("walk column beyond the states in use");

    // A row fill only happens on a row that still reads as uniform.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_FILL) |-> !row_valid_reg[row_reg])
        else $error("row fill on a row already written");

    // A result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> $stable(m_state_reg) && $stable(m_status_reg))
        else $error("pending result overwritten");
`endif

endmodule

// ===== tb/markov_chain_state_sampler_core_tb.sv =====
// ----------------------------------------------------------------------------
// markov_chain_state_sampler_core_tb
// Self-checking testbench for the Markov chain state sampler. A directed run
// covers the corner cases: field extremes, rejected indices and counts,
// undefined operations and an all-zero row. A long random run follows. Each
// accepted input transaction is passed to a scoreboard that predicts the
// sampler's state. Each result transaction is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module markov_chain_state_sampler_core_tb;

    localparam int MAX_STATES   = 16;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 300;
    // Highest code that the opcode field can carry; codes above OP_RESIZE are undefined.
    localparam logic [mcss_pkg::OPCODE_W-1:0] OP_CODE_MAX = '1;

    typedef struct packed {
        logic [mcss_pkg::STATE_NUM_W-1:0] state_number;
        logic                             status;
    } sample_result_t;

    // Scoreboard: keeps its own copy of the weight table, the row sums,
    // the current state and the number of states in use.
    class sampler_scoreboard;
        bit [mcss_pkg::WEIGHT_IN_W-1:0] weight_tab [MAX_STATES][MAX_STATES];
        bit [19:0]                      row_total [MAX_STATES];
        bit [mcss_pkg::ROW_W-1:0]       cur_state;
        bit [mcss_pkg::COUNT_W-1:0]     used_states;
        sample_result_t                 due_q [$];
        int unsigned                    errors;

        function new();
            used_states = mcss_pkg::COUNT_W'(3);
            cur_state   = '0;
            errors      = 0;
            fill_uniform();
        endfunction

        function void fill_uniform();
            foreach (weight_tab[r, c]) weight_tab[r][c] = mcss_pkg::WEIGHT_IN_W'(1);
            foreach (row_total[r]) row_total[r] = 20'(used_states);
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Applies one accepted input transaction and queues the result it causes.
        function void note_input(logic [mcss_pkg::OPCODE_W-1:0] op,
                                 logic [mcss_pkg::S_TDATA_W-1:0] data);
            logic [mcss_pkg::FRAC_IN_W-1:0]   frac;
            logic [mcss_pkg::ROW_W-1:0]       row;
            logic [mcss_pkg::COL_W-1:0]       col;
            logic [mcss_pkg::WEIGHT_IN_W-1:0] weight;
            logic [mcss_pkg::COUNT_W-1:0]     count;
            bit [35:0]                        scaled;
            bit [19:0]                        threshold;
            bit [19:0]                        running;
            bit                               found;
            sample_result_t                   res;
            frac   = data[mcss_pkg::FRAC_LSB +: mcss_pkg::FRAC_IN_W];
            row    = data[mcss_pkg::ROW_LSB +: mcss_pkg::ROW_W];
            col    = data[mcss_pkg::COL_LSB +: mcss_pkg::COL_W];
            weight = data[mcss_pkg::WEIGHT_LSB +: mcss_pkg::WEIGHT_IN_W];
            count  = data[mcss_pkg::COUNT_LSB +: mcss_pkg::COUNT_W];
            res.status = mcss_pkg::STATUS_OK;
            case (op)
                mcss_pkg::OP_STEP: begin
                    // A row whose weights are all zero leaves the state where it is.
                    if (row_total[cur_state] != 0) begin
                        scaled    = 36'(frac) * 36'(row_total[cur_state]);
                        threshold = scaled[35:mcss_pkg::FRAC_IN_W];
                        running   = '0;
                        found     = 1'b0;
                        for (int j = 0; j < int'(used_states); j++) begin
                            if (!found) begin
                                running += 20'(weight_tab[cur_state][j]);
                                if (threshold < running) begin
                                    cur_state = mcss_pkg::ROW_W'(j);
                                    found     = 1'b1;
                                end
                            end
                        end
                    end
                end
                mcss_pkg::OP_SET_STATE: begin
                    if (mcss_pkg::COUNT_W'(row) < used_states) cur_state = row;
                    else res.status = mcss_pkg::STATUS_ERROR;
                end
                mcss_pkg::OP_WRITE_WEIGHT: begin
                    if (mcss_pkg::COUNT_W'(row) < used_states &&
                        mcss_pkg::COUNT_W'(col) < used_states) begin
                        row_total[row] = row_total[row] - 20'(weight_tab[row][col])
                                         + 20'(weight);
                        weight_tab[row][col] = weight;
                    end else begin
                        res.status = mcss_pkg::STATUS_ERROR;
                    end
                end
                mcss_pkg::OP_RESET_UNIFORM: fill_uniform();
                mcss_pkg::OP_RESIZE: begin
                    if (count >= 1 && count <= MAX_STATES) begin
                        used_states = count;
                        if (mcss_pkg::COUNT_W'(cur_state) >= count) cur_state = '0;
                        fill_uniform();
                    end else begin
                        res.status = mcss_pkg::STATUS_ERROR;
                    end
                end
                default: res.status = mcss_pkg::STATUS_ERROR;
            endcase
            res.state_number = mcss_pkg::STATE_NUM_W'(cur_state) +
                               mcss_pkg::STATE_NUM_W'(1);
            due_q = {due_q, res};
        endfunction

        // Compares one result transaction with the oldest prediction.
        function void check_result(logic [mcss_pkg::M_TDATA_W-1:0] data);
            sample_result_t want;
            logic [mcss_pkg::STATE_NUM_W-1:0] got_state;
            logic got_status;
            got_state  = data[mcss_pkg::STATE_NUM_W-1:0];
            got_status = data[mcss_pkg::STATE_NUM_W];
            if (due_q.size() == 0) begin
                $error("result transaction with no expected result waiting: %s %0d, %s %0d",
                       "state_number", got_state, "status", got_status);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got_state !== want.state_number) begin
                $error("state_number: expected %0d, actual %0d", want.state_number, got_state);
                errors++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mcss_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic [mcss_pkg::OPCODE_W-1:0]    s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mcss_pkg::M_TDATA_W-1:0]   m_tdata;

    sampler_scoreboard sb = new();

    // Idle rates in percent of cycles; changed per phase by the stimulus.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Long receiver hold-offs are asked for by bumping hold_asked.
    int hold_asked       = 0;
    int hold_granted     = 0;
    int hold_cycles_left = 0;

    markov_chain_state_sampler_core #(
        .MAX_STATES    (MAX_STATES),
        .WEIGHT_BITS   (mcss_pkg::WEIGHT_IN_W),
        .FRACTION_BITS (mcss_pkg::FRAC_IN_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Receiver: random back-pressure, with the occasional long hold-off that is
    // counted here so that the sampler fills up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles_left != 0) begin
            m_tready         <= 1'b0;
            hold_cycles_left <= hold_cycles_left - 1;
        end else if (hold_granted != hold_asked) begin
            m_tready         <= 1'b0;
            hold_cycles_left <= HOLD_CYCLES;
            hold_granted     <= hold_asked;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: both channels are sampled at the rising edge, before the
    // testbench's own nonblocking updates take effect.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Offers one input transaction after a random idle gap and returns at the
    // edge where it is accepted.
    task automatic send_item(input logic [mcss_pkg::OPCODE_W-1:0]    op,
                             input logic [mcss_pkg::FRAC_IN_W-1:0]   frac,
                             input logic [mcss_pkg::ROW_W-1:0]       row,
                             input logic [mcss_pkg::COL_W-1:0]       col,
                             input logic [mcss_pkg::WEIGHT_IN_W-1:0] weight,
                             input logic [mcss_pkg::COUNT_W-1:0]     count);
        logic [mcss_pkg::S_TDATA_W-1:0] data;
        int gap;
        data = '0;
        data[mcss_pkg::FRAC_LSB +: mcss_pkg::FRAC_IN_W]     = frac;
        data[mcss_pkg::ROW_LSB +: mcss_pkg::ROW_W]          = row;
        data[mcss_pkg::COL_LSB +: mcss_pkg::COL_W]          = col;
        data[mcss_pkg::WEIGHT_LSB +: mcss_pkg::WEIGHT_IN_W] = weight;
        data[mcss_pkg::COUNT_LSB +: mcss_pkg::COUNT_W]      = count;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering until every predicted result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        int kind;
        int gen_used;
        logic [mcss_pkg::OPCODE_W-1:0]    op;
        logic [mcss_pkg::FRAC_IN_W-1:0]   frac;
        logic [mcss_pkg::ROW_W-1:0]       row;
        logic [mcss_pkg::COL_W-1:0]       col;
        logic [mcss_pkg::WEIGHT_IN_W-1:0] weight;
        logic [mcss_pkg::COUNT_W-1:0]     count;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // First phase: sender idles 31 percent, receiver 47 percent.
        tx_idle_pct = 31;
        rx_idle_pct = 47;

        // Directed part, starting from three states with uniform weights.
        send_item(mcss_pkg::OP_STEP, '0, '0, '0, '0, '0);              // lowest fraction
        send_item(mcss_pkg::OP_STEP, '1, '0, '0, '0, '0);              // highest fraction
        send_item(mcss_pkg::OP_SET_STATE, '0, 4'd1, '0, '0, '0);
        send_item(mcss_pkg::OP_SET_STATE, '0, 4'd3, '0, '0, '0);       // just out of range
        send_item(mcss_pkg::OP_SET_STATE, '0, '1, '0, '0, '0);
        send_item(mcss_pkg::OP_WRITE_WEIGHT, '0, 4'd3, '0, 16'd9, '0); // row out of range
        send_item(mcss_pkg::OP_WRITE_WEIGHT, '0, '0, '1, 16'd9, '0);   // column out of range
        send_item(mcss_pkg::OP_RESIZE + 3'd1, '1, '1, '1, '1, '1);     // undefined codes
        send_item(OP_CODE_MAX, '0, '0, '0, '0, '0);
        send_item(mcss_pkg::OP_RESIZE, '0, '0, '0, '0, '0);            // zero count
        send_item(mcss_pkg::OP_RESIZE, '0, '0, '0, '0, 5'd17);         // count above maximum
        send_item(mcss_pkg::OP_RESIZE, '0, '0, '0, '0, '1);
        send_item(mcss_pkg::OP_RESIZE, '0, '0, '0, '0, 5'd16);         // largest table
        send_item(mcss_pkg::OP_SET_STATE, '0, '1, '0, '0, '0);
        send_item(mcss_pkg::OP_WRITE_WEIGHT, '0, '1, '1, '1, '0);      // largest weight
        send_item(mcss_pkg::OP_WRITE_WEIGHT, '0, '1, '0, '0, '0);
        send_item(mcss_pkg::OP_STEP, '1, '0, '0, '0, '0);
        send_item(mcss_pkg::OP_STEP, '0, '0, '0, '0, '0);              // skips zero weight
        send_item(mcss_pkg::OP_RESET_UNIFORM, '0, '0, '0, '0, '0);
        send_item(mcss_pkg::OP_RESIZE, '0, '0, '0, '0, 5'd1);          // state falls to zero
        send_item(mcss_pkg::OP_WRITE_WEIGHT, '0, '0, '0, '0, '0);      // row sum becomes zero
        send_item(mcss_pkg::OP_STEP, 16'h8000, '0, '0, '0, '0);        // state holds
        send_item(mcss_pkg::OP_RESIZE, '0, '0, '0, '0, 5'd2);
        send_item(mcss_pkg::OP_WRITE_WEIGHT, '0, '0, 4'd1, '0, '0);
        send_item(mcss_pkg::OP_STEP, '1, '0, '0, '0, '0);
        send_item(mcss_pkg::OP_RESIZE, '0, '0, '0, '0, 5'd3);
        gen_used = 3;

        // Random part. Most transactions are well-formed: steps mixed with
        // in-range weight writes, so that rows become skewed or empty.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 700) begin
                tx_idle_pct = 47;
                rx_idle_pct = 31;
            end
            if (i == 1400) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 300 || i == 1600) hold_asked <= hold_asked + 1;
            if (i == 1100) drain_results();

            frac   = mcss_pkg::FRAC_IN_W'($urandom);
            row    = mcss_pkg::ROW_W'($urandom);
            col    = mcss_pkg::COL_W'($urandom);
            weight = mcss_pkg::WEIGHT_IN_W'($urandom);
            count  = mcss_pkg::COUNT_W'($urandom);
            kind   = $urandom_range(0, 99);
            if (kind < 50) begin
                op = mcss_pkg::OP_STEP;
                if ($urandom_range(0, 9) == 0) frac = $urandom_range(0, 1) ? '1 : '0;
            end else if (kind < 78) begin
                op = mcss_pkg::OP_WRITE_WEIGHT;
                if ($urandom_range(0, 9) != 0) begin
                    row = mcss_pkg::ROW_W'($urandom_range(0, gen_used - 1));
                    col = mcss_pkg::COL_W'($urandom_range(0, gen_used - 1));
                end
                case ($urandom_range(0, 3))
                    0: weight = '0;
                    1: weight = mcss_pkg::WEIGHT_IN_W'($urandom_range(1, 7));
                    2: if ($urandom_range(0, 3) == 0) weight = '1;
                    default: ;
                endcase
            end else if (kind < 85) begin
                op = mcss_pkg::OP_SET_STATE;
                if ($urandom_range(0, 6) != 0) begin
                    row = mcss_pkg::ROW_W'($urandom_range(0, gen_used - 1));
                end
            end else if (kind < 88) begin
                op = mcss_pkg::OP_RESET_UNIFORM;
            end else if (kind < 96) begin
                op = mcss_pkg::OP_RESIZE;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: count = mcss_pkg::COUNT_W'($urandom_range(1, 6));
                    6, 7, 8:          count = mcss_pkg::COUNT_W'($urandom_range(1, MAX_STATES));
                    default: ;  // any count, out-of-range ones included
                endcase
                if (count >= 1 && count <= MAX_STATES) gen_used = count;
            end else begin
                op = mcss_pkg::OPCODE_W'($urandom_range(int'(mcss_pkg::OP_RESIZE) + 1,
                                                        int'(OP_CODE_MAX)));
            end
            send_item(op, frac, row, col, weight, count);
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then give the sampler time to show any
        // stray transaction.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("markov_chain_state_sampler_core_tb: clean");
        end else begin
            $display("markov_chain_state_sampler_core_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("markov_chain_state_sampler_core_tb: errors");
        $finish;
    end

endmodule
